### sv/fsp_pkg.sv
// Shared types, constants and decode functions for the format specification parser.
// Used by fsp_core, format_spec_parser, fsp_checker and the testbench; depends on nothing else.
package fsp_pkg;

    localparam int COUNT_BITS = 16;
    localparam int PROD_W     = COUNT_BITS + 4;

    localparam logic [COUNT_BITS-1:0] SAT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_FLAGS  = 3'd1,
        PH_WDIG   = 3'd2,
        PH_AFTERW = 3'd3,
        PH_PSTART = 3'd4,
        PH_PDIG   = 3'd5,
        PH_LEN    = 3'd6,
        PH_CONV   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PCT   = 2'd1,
        ST_BAD   = 2'd2,
        ST_UNSUP = 2'd3
    } t_status;

    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_HH   = 4'd1;
    localparam logic [3:0] LEN_H    = 4'd2;
    localparam logic [3:0] LEN_L    = 4'd3;
    localparam logic [3:0] LEN_LL   = 4'd4;
    localparam logic [3:0] LEN_J    = 4'd5;
    localparam logic [3:0] LEN_Z    = 4'd6;
    localparam logic [3:0] LEN_T    = 4'd7;
    localparam logic [3:0] LEN_BIGL = 4'd8;

    localparam int FLAG_MINUS = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_ALT   = 2;
    localparam int FLAG_SPACE = 3;
    localparam int FLAG_ZERO  = 4;

    localparam logic [4:0] CONV_D    = 5'd0;
    localparam logic [4:0] CONV_I    = 5'd1;
    localparam logic [4:0] CONV_O    = 5'd2;
    localparam logic [4:0] CONV_U    = 5'd3;
    localparam logic [4:0] CONV_X    = 5'd4;
    localparam logic [4:0] CONV_X_UC = 5'd5;
    localparam logic [4:0] CONV_F    = 5'd6;
    localparam logic [4:0] CONV_F_UC = 5'd7;
    localparam logic [4:0] CONV_E    = 5'd8;
    localparam logic [4:0] CONV_E_UC = 5'd9;
    localparam logic [4:0] CONV_G    = 5'd10;
    localparam logic [4:0] CONV_G_UC = 5'd11;
    localparam logic [4:0] CONV_A    = 5'd12;
    localparam logic [4:0] CONV_A_UC = 5'd13;
    localparam logic [4:0] CONV_C    = 5'd14;
    localparam logic [4:0] CONV_S    = 5'd15;
    localparam logic [4:0] CONV_P    = 5'd16;
    localparam logic [4:0] CONV_N    = 5'd17;

    localparam logic [4:0] RADIX_NONE  = 5'd0;
    localparam logic [4:0] RADIX_FLOAT = 5'd2;
    localparam logic [4:0] RADIX_OCT   = 5'd8;
    localparam logic [4:0] RADIX_DEC   = 5'd10;
    localparam logic [4:0] RADIX_HEX   = 5'd16;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_BIGL  = 8'h4C;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [15:0] star_value;
    } t_item;

    typedef struct packed {
        t_status         status;
        logic [4:0]      align_flags;
        logic [15:0]     field_width;
        logic            prec_valid;
        logic [15:0]     precision;
        logic [3:0]      length_code;
        logic [4:0]      conv_code;
        logic [4:0]      radix;
        logic            is_unsigned;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
        logic [4:0] radix;
        logic       is_unsigned;
    } t_conv;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [COUNT_BITS-1:0] add_digit(
        input logic [COUNT_BITS-1:0] acc,
        input logic [7:0]            c
    );
        logic [PROD_W-1:0] v;
        v = PROD_W'(acc) * PROD_W'(10) + PROD_W'(c[3:0]);
        return (v > PROD_W'(SAT_MAX)) ? SAT_MAX : v[COUNT_BITS-1:0];
    endfunction

    // A star magnitude is at most 32768, so it only saturates for narrow counters.
    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [15:0] mag);
        return (32'(mag) > 32'(SAT_MAX)) ? SAT_MAX : COUNT_BITS'(mag);
    endfunction

    function automatic t_conv conv_lookup(input logic [7:0] c);
        t_conv r;
        r = '{hit: 1'b1, code: CONV_D, radix: RADIX_NONE, is_unsigned: 1'b0};
        unique case (c)
            "d": begin r.code = CONV_D;    r.radix = RADIX_DEC; end
            "i": begin r.code = CONV_I;    r.radix = RADIX_DEC; end
            "o": begin r.code = CONV_O;    r.radix = RADIX_OCT; r.is_unsigned = 1'b1; end
            "u": begin r.code = CONV_U;    r.radix = RADIX_DEC; r.is_unsigned = 1'b1; end
            "x": begin r.code = CONV_X;    r.radix = RADIX_HEX; r.is_unsigned = 1'b1; end
            "X": begin r.code = CONV_X_UC; r.radix = RADIX_HEX; r.is_unsigned = 1'b1; end
            "f": begin r.code = CONV_F;    r.radix = RADIX_FLOAT; end
            "F": begin r.code = CONV_F_UC; r.radix = RADIX_FLOAT; end
            "e": begin r.code = CONV_E;    r.radix = RADIX_FLOAT; end
            "E": begin r.code = CONV_E_UC; r.radix = RADIX_FLOAT; end
            "g": begin r.code = CONV_G;    r.radix = RADIX_FLOAT; end
            "G": begin r.code = CONV_G_UC; r.radix = RADIX_FLOAT; end
            "a": begin r.code = CONV_A;    r.radix = RADIX_FLOAT; end
            "A": begin r.code = CONV_A_UC; r.radix = RADIX_FLOAT; end
            "c": begin r.code = CONV_C; end
            "s": begin r.code = CONV_S; end
            "p": begin r.code = CONV_P; r.radix = RADIX_HEX; r.is_unsigned = 1'b1; end
            "n": begin r.code = CONV_N; end
            default: begin r.hit = 1'b0; end
        endcase
        return r;
    endfunction

endpackage

### sv/fsp_core.sv
// Parse state registers and the per-character step logic of the specification parser.
// Depends on fsp_pkg.
module fsp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  fsp_pkg::t_item   i_item,
    output logic             o_emit,
    output fsp_pkg::t_result o_result
);

    fsp_pkg::t_phase                  r_phase, n_phase;
    logic [4:0]                       r_flags, n_flags;
    logic [fsp_pkg::COUNT_BITS-1:0]   r_width, n_width;
    logic [fsp_pkg::COUNT_BITS-1:0]   r_prec, n_prec;
    logic                             r_prec_seen, n_prec_seen;
    logic [3:0]                       r_length, n_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fsp_pkg::PH_START;
            r_flags     <= '0;
            r_width     <= '0;
            r_prec      <= '0;
            r_prec_seen <= 1'b0;
            r_length    <= fsp_pkg::LEN_NONE;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_flags     <= n_flags;
            r_width     <= n_width;
            r_prec      <= n_prec;
            r_prec_seen <= n_prec_seen;
            r_length    <= n_length;
        end
    end

    always_comb begin
        fsp_pkg::t_phase p;
        logic            done;
        logic [4:0]      fbit;
        logic [3:0]      lcode;
        logic [7:0]      c;
        logic [15:0]     mag;
        fsp_pkg::t_conv  cv;

        c           = i_item.ch;
        n_phase     = r_phase;
        n_flags     = r_flags;
        n_width     = r_width;
        n_prec      = r_prec;
        n_prec_seen = r_prec_seen;
        n_length    = r_length;
        o_emit      = 1'b0;
        o_result    = '0;
        done        = 1'b0;
        p           = r_phase;
        fbit        = '0;
        lcode       = fsp_pkg::LEN_NONE;
        mag         = '0;
        cv          = fsp_pkg::conv_lookup(c);

        if (p == fsp_pkg::PH_START) begin
            if (c == fsp_pkg::CH_PCT) begin
                o_emit          = 1'b1;
                o_result.status = fsp_pkg::ST_PCT;
                done            = 1'b1;
            end else begin
                p = fsp_pkg::PH_FLAGS;
            end
        end

        if (!done && p == fsp_pkg::PH_FLAGS) begin
            unique case (c)
                fsp_pkg::CH_MINUS: fbit[fsp_pkg::FLAG_MINUS] = 1'b1;
                fsp_pkg::CH_PLUS:  fbit[fsp_pkg::FLAG_PLUS]  = 1'b1;
                fsp_pkg::CH_HASH:  fbit[fsp_pkg::FLAG_ALT]   = 1'b1;
                fsp_pkg::CH_SPACE: fbit[fsp_pkg::FLAG_SPACE] = 1'b1;
                fsp_pkg::CH_ZERO:  fbit[fsp_pkg::FLAG_ZERO]  = 1'b1;
                default:           fbit = '0;
            endcase
            if (fbit != '0) begin
                n_flags = r_flags | fbit;
                n_phase = fsp_pkg::PH_FLAGS;
                done    = 1'b1;
            end else if (c == fsp_pkg::CH_STAR) begin
                if (i_item.star_value < 0) begin
                    n_flags[fsp_pkg::FLAG_MINUS] = 1'b1;
                    mag = 16'(-i_item.star_value);
                end else begin
                    mag = 16'(i_item.star_value);
                end
                n_width = fsp_pkg::sat_count(mag);
                n_phase = fsp_pkg::PH_AFTERW;
                done    = 1'b1;
            end else if (c >= fsp_pkg::CH_ONE && c <= fsp_pkg::CH_NINE) begin
                n_width = fsp_pkg::add_digit('0, c);
                n_phase = fsp_pkg::PH_WDIG;
                done    = 1'b1;
            end else begin
                p = fsp_pkg::PH_AFTERW;
            end
        end

        if (!done && p == fsp_pkg::PH_WDIG) begin
            if (fsp_pkg::is_digit(c)) begin
                n_width = fsp_pkg::add_digit(r_width, c);
                done    = 1'b1;
            end else begin
                p = fsp_pkg::PH_AFTERW;
            end
        end

        if (!done && p == fsp_pkg::PH_AFTERW) begin
            if (c == fsp_pkg::CH_DOT) begin
                n_prec_seen                 = 1'b1;
                n_prec                      = '0;
                n_flags[fsp_pkg::FLAG_ZERO] = 1'b0;
                n_phase                     = fsp_pkg::PH_PSTART;
                done                        = 1'b1;
            end else begin
                p = fsp_pkg::PH_LEN;
            end
        end

        if (!done && p == fsp_pkg::PH_PSTART) begin
            if (c == fsp_pkg::CH_STAR) begin
                if (i_item.star_value < 0) begin
                    n_prec_seen = 1'b0;
                    n_prec      = '0;
                end else begin
                    n_prec = fsp_pkg::sat_count(16'(i_item.star_value));
                end
                n_phase = fsp_pkg::PH_LEN;
                done    = 1'b1;
            end else begin
                p = fsp_pkg::PH_PDIG;
            end
        end

        if (!done && p == fsp_pkg::PH_PDIG) begin
            if (fsp_pkg::is_digit(c)) begin
                n_prec  = fsp_pkg::add_digit(r_prec, c);
                n_phase = fsp_pkg::PH_PDIG;
                done    = 1'b1;
            end else begin
                p = fsp_pkg::PH_LEN;
            end
        end

        if (!done && p == fsp_pkg::PH_LEN) begin
            unique case (c)
                fsp_pkg::CH_H:    lcode = fsp_pkg::LEN_H;
                fsp_pkg::CH_L:    lcode = fsp_pkg::LEN_L;
                fsp_pkg::CH_J:    lcode = fsp_pkg::LEN_J;
                fsp_pkg::CH_Z:    lcode = fsp_pkg::LEN_Z;
                fsp_pkg::CH_T:    lcode = fsp_pkg::LEN_T;
                fsp_pkg::CH_BIGL: lcode = fsp_pkg::LEN_BIGL;
                default:          lcode = fsp_pkg::LEN_NONE;
            endcase
            if (lcode != fsp_pkg::LEN_NONE) begin
                n_length = lcode;
                n_phase  = fsp_pkg::PH_CONV;
                done     = 1'b1;
            end
        end

        if (!done && r_phase == fsp_pkg::PH_CONV) begin
            if (r_length == fsp_pkg::LEN_H && c == fsp_pkg::CH_H) begin
                n_length = fsp_pkg::LEN_HH;
                done     = 1'b1;
            end else if (r_length == fsp_pkg::LEN_L && c == fsp_pkg::CH_L) begin
                n_length = fsp_pkg::LEN_LL;
                done     = 1'b1;
            end
        end

        if (!done) begin
            o_emit               = 1'b1;
            o_result.status      = fsp_pkg::ST_BAD;
            o_result.align_flags = r_flags;
            o_result.field_width = 16'(r_width);
            o_result.prec_valid  = r_prec_seen;
            o_result.precision   = r_prec_seen ? 16'(r_prec) : 16'd0;
            o_result.length_code = r_length;
            if (cv.hit) begin
                o_result.status      = fsp_pkg::ST_OK;
                o_result.conv_code   = cv.code;
                o_result.radix       = cv.radix;
                o_result.is_unsigned = cv.is_unsigned;
                if (cv.code == fsp_pkg::CONV_P) begin
                    o_result.align_flags[fsp_pkg::FLAG_ALT] = 1'b1;
                    if (r_length >= fsp_pkg::LEN_HH && r_length <= fsp_pkg::LEN_Z) begin
                        o_result.status = fsp_pkg::ST_UNSUP;
                    end
                end
            end
        end

        if (o_emit) begin
            n_phase     = fsp_pkg::PH_START;
            n_flags     = '0;
            n_width     = '0;
            n_prec      = '0;
            n_prec_seen = 1'b0;
            n_length    = fsp_pkg::LEN_NONE;
        end
    end

endmodule

### sv/format_spec_parser.sv
// Top level: input item register, fsp_core step logic and the result register.
// Path: an accepted item is held in the input item register, and the result it completes in the result register.
// Throughput: one character item per cycle; the state update is one decode plus a
// multiply by ten. The input stalls only while an item waits and a result is held.
// Reset (synchronous, active low) empties both registers and returns the parse state
// to the start of a specification with flags, width, precision and length cleared.
module format_spec_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ch,
    input  logic signed [15:0] i_star_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [4:0]         o_align_flags,
    output logic [15:0]        o_field_width,
    output logic               o_prec_valid,
    output logic [15:0]        o_precision,
    output logic [3:0]         o_length_code,
    output logic [4:0]         o_conv_code,
    output logic [4:0]         o_radix,
    output logic               o_is_unsigned
);

    logic             r_in_vld;
    fsp_pkg::t_item   r_item;
    logic             r_out_vld;
    fsp_pkg::t_result r_out;
    logic             w_adv;
    logic             w_emit;
    fsp_pkg::t_result w_result;

    assign w_adv   = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.ch         <= i_ch;
            r_item.star_value <= i_star_value;
        end
    end

    fsp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_item),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_emit;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_out.status;
    assign o_align_flags = r_out.align_flags;
    assign o_field_width = r_out.field_width;
    assign o_prec_valid  = r_out.prec_valid;
    assign o_precision   = r_out.precision;
    assign o_length_code = r_out.length_code;
    assign o_conv_code   = r_out.conv_code;
    assign o_radix       = r_out.radix;
    assign o_is_unsigned = r_out.is_unsigned;

`ifndef SYNTHESIS
    a_pct_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fsp_pkg::ST_PCT) |->
            (o_align_flags == 5'd0 && o_field_width == 16'd0 && o_prec_valid == 1'b0 &&
             o_length_code == fsp_pkg::LEN_NONE && o_conv_code == 5'd0 &&
             o_radix == fsp_pkg::RADIX_NONE))
        else $error("literal percent result carries nonzero fields");

    a_prec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_prec_valid) |-> (o_precision == 16'd0))
        else $error("precision nonzero without a valid precision");

    a_bad_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fsp_pkg::ST_BAD) |->
            (o_conv_code == 5'd0 && o_radix == fsp_pkg::RADIX_NONE && !o_is_unsigned))
        else $error("bad conversion result carries conversion fields");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_vld)
        else $error("accepted item lost from the input register");
`endif

endmodule

### dv/fsp_checker.sv
`timescale 1ns / 1ps
// Checker for format_spec_parser: watches both item channels, predicts each result
// from the accepted characters and compares field by field. Depends on fsp_pkg.
module fsp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_ch,
    input  logic signed [15:0] i_star_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic [4:0]         i_align_flags,
    input  logic [15:0]        i_field_width,
    input  logic               i_prec_valid,
    input  logic [15:0]        i_precision,
    input  logic [3:0]         i_length_code,
    input  logic [4:0]         i_conv_code,
    input  logic [4:0]         i_radix,
    input  logic               i_is_unsigned,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam string CONV_LETTERS = "diouxXfFeEgGaAcspn";

    fsp_pkg::t_phase  spec_phase;
    logic [4:0]       spec_flags;
    logic [15:0]      spec_width;
    logic [15:0]      spec_prec;
    logic             spec_has_prec;
    logic [3:0]       spec_len;

    fsp_pkg::t_result spec_results[$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
    endfunction

    function automatic logic [15:0] next_count(input logic [15:0] acc, input logic [7:0] c);
        int unsigned v;
        v = acc * 10 + (c - fsp_pkg::CH_ZERO);
        return (v > fsp_pkg::SAT_MAX) ? fsp_pkg::SAT_MAX : v[15:0];
    endfunction

    function automatic logic [4:0] radix_of(input logic [7:0] c);
        unique case (c) inside
            "d", "i", "u": return fsp_pkg::RADIX_DEC;
            "o": return fsp_pkg::RADIX_OCT;
            "x", "X", "p": return fsp_pkg::RADIX_HEX;
            "c", "s", "n": return fsp_pkg::RADIX_NONE;
            default: return fsp_pkg::RADIX_FLOAT;
        endcase
    endfunction

    task automatic clear_spec_state();
        spec_phase    = fsp_pkg::PH_START;
        spec_flags    = '0;
        spec_width    = '0;
        spec_prec     = '0;
        spec_has_prec = 1'b0;
        spec_len      = fsp_pkg::LEN_NONE;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic signed [15:0] sv,
                              output bit emit, output fsp_pkg::t_result r);
        fsp_pkg::t_phase p;
        logic [3:0]      len_code;
        int              k;
        bit              found;
        p = spec_phase;
        emit = 1'b0;
        r = '0;
        if (p == fsp_pkg::PH_START) begin
            if (c == fsp_pkg::CH_PCT) begin
                r.status = fsp_pkg::ST_PCT;
                emit = 1'b1;
                clear_spec_state();
                return;
            end
            p = fsp_pkg::PH_FLAGS;
        end
        if (p == fsp_pkg::PH_FLAGS) begin
            unique case (c)
                fsp_pkg::CH_MINUS: begin
                    spec_flags[fsp_pkg::FLAG_MINUS] = 1'b1;
                    spec_phase = fsp_pkg::PH_FLAGS;
                    return;
                end
                fsp_pkg::CH_PLUS: begin
                    spec_flags[fsp_pkg::FLAG_PLUS] = 1'b1;
                    spec_phase = fsp_pkg::PH_FLAGS;
                    return;
                end
                fsp_pkg::CH_HASH: begin
                    spec_flags[fsp_pkg::FLAG_ALT] = 1'b1;
                    spec_phase = fsp_pkg::PH_FLAGS;
                    return;
                end
                fsp_pkg::CH_SPACE: begin
                    spec_flags[fsp_pkg::FLAG_SPACE] = 1'b1;
                    spec_phase = fsp_pkg::PH_FLAGS;
                    return;
                end
                fsp_pkg::CH_ZERO: begin
                    spec_flags[fsp_pkg::FLAG_ZERO] = 1'b1;
                    spec_phase = fsp_pkg::PH_FLAGS;
                    return;
                end
                default: ;
            endcase
            if (c == fsp_pkg::CH_STAR) begin
                if (sv < 0) begin
                    spec_flags[fsp_pkg::FLAG_MINUS] = 1'b1;
                    spec_width = 16'(-int'(sv));
                end else begin
                    spec_width = 16'(sv);
                end
                spec_phase = fsp_pkg::PH_AFTERW;
                return;
            end
            if (c >= fsp_pkg::CH_ONE && c <= fsp_pkg::CH_NINE) begin
                spec_width = next_count(16'd0, c);
                spec_phase = fsp_pkg::PH_WDIG;
                return;
            end
            p = fsp_pkg::PH_AFTERW;
        end
        if (p == fsp_pkg::PH_WDIG) begin
            if (is_numeral(c)) begin
                spec_width = next_count(spec_width, c);
                return;
            end
            p = fsp_pkg::PH_AFTERW;
        end
        if (p == fsp_pkg::PH_AFTERW) begin
            if (c == fsp_pkg::CH_DOT) begin
                spec_has_prec = 1'b1;
                spec_prec = '0;
                spec_flags[fsp_pkg::FLAG_ZERO] = 1'b0;
                spec_phase = fsp_pkg::PH_PSTART;
                return;
            end
            p = fsp_pkg::PH_LEN;
        end
        if (p == fsp_pkg::PH_PSTART) begin
            if (c == fsp_pkg::CH_STAR) begin
                if (sv < 0) begin
                    spec_has_prec = 1'b0;
                    spec_prec = '0;
                end else begin
                    spec_prec = 16'(sv);
                end
                spec_phase = fsp_pkg::PH_LEN;
                return;
            end
            p = fsp_pkg::PH_PDIG;
        end
        if (p == fsp_pkg::PH_PDIG) begin
            if (is_numeral(c)) begin
                spec_prec = next_count(spec_prec, c);
                spec_phase = fsp_pkg::PH_PDIG;
                return;
            end
            p = fsp_pkg::PH_LEN;
        end
        if (p == fsp_pkg::PH_LEN) begin
            unique case (c)
                fsp_pkg::CH_H:    len_code = fsp_pkg::LEN_H;
                fsp_pkg::CH_L:    len_code = fsp_pkg::LEN_L;
                fsp_pkg::CH_J:    len_code = fsp_pkg::LEN_J;
                fsp_pkg::CH_Z:    len_code = fsp_pkg::LEN_Z;
                fsp_pkg::CH_T:    len_code = fsp_pkg::LEN_T;
                fsp_pkg::CH_BIGL: len_code = fsp_pkg::LEN_BIGL;
                default:          len_code = fsp_pkg::LEN_NONE;
            endcase
            if (len_code != fsp_pkg::LEN_NONE) begin
                spec_len = len_code;
                spec_phase = fsp_pkg::PH_CONV;
                return;
            end
        end
        if (spec_phase == fsp_pkg::PH_CONV && spec_len == fsp_pkg::LEN_H
                && c == fsp_pkg::CH_H) begin
            spec_len = fsp_pkg::LEN_HH;
            return;
        end
        if (spec_phase == fsp_pkg::PH_CONV && spec_len == fsp_pkg::LEN_L
                && c == fsp_pkg::CH_L) begin
            spec_len = fsp_pkg::LEN_LL;
            return;
        end

        r.status = fsp_pkg::ST_BAD;
        found = 1'b0;
        for (k = 0; k < CONV_LETTERS.len(); k++) begin
            if (!found && CONV_LETTERS[k] == c) begin
                found = 1'b1;
                r.status = fsp_pkg::ST_OK;
                r.conv_code = 5'(k);
                r.radix = radix_of(c);
                r.is_unsigned = (r.radix == fsp_pkg::RADIX_OCT) ||
                                (r.radix == fsp_pkg::RADIX_HEX) || (c == "u");
                if (r.conv_code == fsp_pkg::CONV_P) begin
                    spec_flags[fsp_pkg::FLAG_ALT] = 1'b1;
                    if (spec_len >= fsp_pkg::LEN_HH && spec_len <= fsp_pkg::LEN_Z) begin
                        r.status = fsp_pkg::ST_UNSUP;
                    end
                end
            end
        end
        r.align_flags = spec_flags;
        r.field_width = spec_width;
        r.prec_valid  = spec_has_prec;
        r.precision   = spec_has_prec ? spec_prec : 16'd0;
        r.length_code = spec_len;
        emit = 1'b1;
        clear_spec_state();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        fsp_pkg::t_result want;
        fsp_pkg::t_result pred;
        bit               emit;
        if (!i_rst_n) begin
            clear_spec_state();
            spec_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (spec_results.size() == 0) begin
                    $error("result arrived with no specification pending");
                    o_fail_count++;
                end else begin
                    want = spec_results.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("align_flags", want.align_flags, i_align_flags);
                    check_field("field_width", want.field_width, i_field_width);
                    check_field("prec_valid", want.prec_valid, i_prec_valid);
                    check_field("precision", want.precision, i_precision);
                    check_field("length_code", want.length_code, i_length_code);
                    check_field("conv_code", want.conv_code, i_conv_code);
                    check_field("radix", want.radix, i_radix);
                    check_field("is_unsigned", want.is_unsigned, i_is_unsigned);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_char(i_ch, i_star_value, emit, pred);
                if (emit) spec_results.push_back(pred);
            end
            o_pending <= spec_results.size();
        end
    end

endmodule

### dv/tb_format_spec_parser.sv
`timescale 1ns / 1ps
// Testbench top for format_spec_parser: drives specification characters with random
// gaps and output stalls and gives the verdict. Depends on fsp_pkg and fsp_checker.
module tb_format_spec_parser;

    localparam int    NUM_ITEMS  = 1600;
    localparam int    IDLE_LIMIT = 2000;
    localparam string FLAG_CHARS = "-+# 0";
    localparam string CONV_CHARS = "diouxXfFeEgGaAcspn";

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_ch = '0;
    logic signed [15:0] i_star_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [4:0]         o_align_flags;
    logic [15:0]        o_field_width;
    logic               o_prec_valid;
    logic [15:0]        o_precision;
    logic [3:0]         o_length_code;
    logic [4:0]         o_conv_code;
    logic [4:0]         o_radix;
    logic               o_is_unsigned;

    int   fail_count;
    int   pending_results;
    int   sent_items = 0;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;
    logic [7:0] spec_text[$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    format_spec_parser DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ch         (i_ch),
        .i_star_value (i_star_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_align_flags(o_align_flags),
        .o_field_width(o_field_width),
        .o_prec_valid (o_prec_valid),
        .o_precision  (o_precision),
        .o_length_code(o_length_code),
        .o_conv_code  (o_conv_code),
        .o_radix      (o_radix),
        .o_is_unsigned(o_is_unsigned)
    );

    fsp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_ch         (i_ch),
        .i_star_value (i_star_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_status     (o_status),
        .i_align_flags(o_align_flags),
        .i_field_width(o_field_width),
        .i_prec_valid (o_prec_valid),
        .i_precision  (o_precision),
        .i_length_code(o_length_code),
        .i_conv_code  (o_conv_code),
        .i_radix      (o_radix),
        .i_is_unsigned(o_is_unsigned),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("format_spec_parser verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic signed [15:0] rand_star();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'($urandom_range(1, 20));
            3: return 16'($urandom_range(0, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [7:0] c, input logic signed [15:0] sv);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch <= c;
        i_star_value <= sv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_spec(input string s, input logic signed [15:0] sv);
        int k;
        for (k = 0; k < s.len(); k++) send_item(s[k], sv);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) spec_text.push_back(s[k]);
    endtask

    task automatic push_digits(input bit nonzero_first);
        int n;
        int k;
        n = ($urandom_range(0, 15) == 0) ? 6 : $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
            if (k == 0 && nonzero_first) begin
                spec_text.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            end else begin
                spec_text.push_back(fsp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
    endtask

    task automatic build_spec();
        int kind;
        int k;
        spec_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 3) begin
            spec_text.push_back(fsp_pkg::CH_PCT);
            return;
        end
        if (kind < 8) begin
            repeat ($urandom_range(1, 4)) spec_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3)) spec_text.push_back(FLAG_CHARS[$urandom_range(0, 4)]);
        kind = $urandom_range(0, 3);
        if (kind == 1) spec_text.push_back(fsp_pkg::CH_STAR);
        else if (kind >= 2) push_digits(1'b1);
        if ($urandom_range(0, 1) == 1) begin
            spec_text.push_back(fsp_pkg::CH_DOT);
            kind = $urandom_range(0, 3);
            if (kind == 1) spec_text.push_back(fsp_pkg::CH_STAR);
            else if (kind >= 2) push_digits(1'b0);
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: ;
            7:  push_text("hh");
            8:  push_text("h");
            9:  push_text("l");
            10: push_text("ll");
            11: push_text("j");
            12: push_text("z");
            13: push_text("t");
            14: push_text("L");
            15: push_text("hhh");
            16: push_text("lll");
            17: push_text("LL");
            default: push_text("hh");
        endcase
        if ($urandom_range(0, 9) == 0) spec_text.push_back(8'($urandom_range(0, 255)));
        else spec_text.push_back(CONV_CHARS[$urandom_range(0, CONV_CHARS.len() - 1)]);
        if ($urandom_range(0, 11) == 0) begin
            k = $urandom_range(0, spec_text.size() - 1);
            spec_text[k] = 8'($urandom_range(0, 255));
        end
    endtask

    initial begin
        int spec_count;
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_spec("%", 16'sd0);
        send_spec("-+# 0*ld", -16'sd32768);
        send_spec("99999.*hhp", 16'sd32767);
        send_spec(".*n", -16'sd1);
        send_spec("hhh", 16'sd0);
        send_spec("5%", 16'sd0);
        send_item(8'h00, 16'sd0);
        send_item(8'hFF, -16'sd1);
        wait_drained();

        spec_count = 0;
        while (sent_items < NUM_ITEMS) begin
            if (spec_count == 250) calm <= 1'b1;
            if (spec_count == 400) calm <= 1'b0;
            if (spec_count % 150 == 149) wait_drained();
            build_spec();
            for (k = 0; k < spec_text.size(); k++) send_item(spec_text[k], rand_star());
            spec_count++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("format_spec_parser verification clean");
        end else begin
            $display("format_spec_parser verification failed");
        end
        $finish;
    end

endmodule
